@@ src/region_table_fault_classifier_defines.svh @@
// Assertion macros for the region table fault classifier.
// Included by the top level; no other dependencies.
`ifndef REGION_TABLE_FAULT_CLASSIFIER_DEFINES_SVH
`define REGION_TABLE_FAULT_CLASSIFIER_DEFINES_SVH

// Implication checked every cycle outside reset.
`define RTFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RTFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/rtfc_pkg.sv @@
// Shared types and constants for the region table fault classifier.
// No dependencies.
package rtfc_pkg;
  localparam int MaxRegions = 16;
  localparam int PageShift  = 12;
  localparam int IdxW       = $clog2(MaxRegions);
  localparam int CntW       = $clog2(MaxRegions + 1);
  localparam int PageW      = 32 - PageShift;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0, CMD_RELEASE = 2'd1, CMD_RANGE = 2'd2, CMD_FAULT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ALIGN = 3'd1, ST_OVERLAP = 3'd2, ST_FULL = 3'd3, ST_DENY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_DEMAND = 2'd1, ACT_COW = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] length;
    logic        want_writable;
    logic        want_user;
    logic        fault_present;
    logic        fault_write;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  fault_action;
    logic        map_writable;
    logic        map_user;
    logic [19:0] page_number;
    logic [4:0]  regions_in_use;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic scan;      // examine entry at scan index, advance
    logic rescan;    // range check: restart lookup at new position
    logic shift;     // one move step for insert/remove
    logic finish;    // apply result (count update, output fields)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic bad_align;     // reserve precheck fails / range wraps
    logic range_zero;
    logic scan_end;      // scan index at count
    logic hit;           // current entry matches
    logic full;
    logic range_done;    // position reached range end
    logic deny;          // hit entry not user (range)
    logic no_service;    // fault on a present page that cannot be copied
    logic shift_done;
  } stat_t;
endpackage

@@ src/rtfc_if.sv @@
// Valid/ready channel carrying one payload type.
// No dependencies.
interface rtfc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/rtfc_datapath.sv @@
// Region table storage and per-entry compare logic.
// Depends on rtfc_pkg.
module rtfc_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtfc_pkg::req_t req_i,
  input  rtfc_pkg::cmd_t cmd_i,
  input  logic [2:0]     res_status_i,
  output rtfc_pkg::stat_t stat_o,
  output rtfc_pkg::rsp_t rsp_o
);
  import rtfc_pkg::*;

  logic [PageW-1:0] start_q [MaxRegions];
  logic [PageW:0]   end_q   [MaxRegions];
  logic             wr_q    [MaxRegions];
  logic             us_q    [MaxRegions];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  mv_q, mv_d;
  req_t             req_q;
  logic [32:0]      pos_q, pos_d;   // range check position
  logic             hw_q, hu_q;     // flags of the hit entry
  rsp_t             rsp_q;

  logic [32:0] r_start, r_end;
  logic [32:0] e_lo, e_hi;
  logic [IdxW-1:0] ix, mx;
  logic hit;

  assign ix = idx_q[IdxW-1:0];
  assign mx = mv_q[IdxW-1:0];
  assign r_start = {1'b0, req_q.address};
  assign r_end   = r_start + {1'b0, req_q.length};
  assign e_lo = {1'b0, start_q[ix], {PageShift{1'b0}}};
  assign e_hi = {end_q[ix], {PageShift{1'b0}}};

  // per-command compare on the entry under the scan index
  always_comb begin
    unique case (cmd_e'(req_q.command))
      CMD_RESERVE: hit = (r_start < e_hi) && (r_end > e_lo);
      CMD_RELEASE: hit = (e_lo == r_start);
      CMD_RANGE:   hit = (pos_q >= e_lo) && (pos_q < e_hi);
      default:     hit = (r_start >= e_lo) && (r_start < e_hi);
    endcase
  end

  always_comb begin
    stat_o.command    = req_q.command;
    stat_o.bad_align  = (req_q.command == CMD_RANGE) ? r_end[32] :
        (((req_q.address | req_q.length) & ((32'd1 << PageShift) - 32'd1)) != 32'd0)
        || (r_end > 33'h1_0000_0000);
    stat_o.range_zero = (req_q.length == 32'd0);
    stat_o.scan_end   = (idx_q >= cnt_q);
    stat_o.hit        = hit;
    stat_o.full       = (cnt_q >= CntW'(MaxRegions));
    stat_o.range_done = (pos_q >= r_end);
    stat_o.deny       = !us_q[ix];
    stat_o.no_service = req_q.fault_present && !(req_q.fault_write && wr_q[ix]);
    stat_o.shift_done = (req_q.command == CMD_RESERVE) ? (mv_q == '0)
                                                       : (mv_q + 1'b1 >= cnt_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    mv_d  = mv_q;
    pos_d = pos_q;
    if (cmd_i.load) begin
      idx_d = '0;
      pos_d = {1'b0, req_i.address};
    end
    if (cmd_i.scan) idx_d = idx_q + 1'b1;
    if (cmd_i.rescan) begin
      idx_d = '0;
      pos_d = e_hi;
    end
    // seed the move index when the scan settles
    if (cmd_i.scan && hit) mv_d = idx_q;
    if (cmd_i.load) mv_d = (req_i.command == CMD_RESERVE) ? cnt_q : '0;
    if (cmd_i.shift) mv_d = (req_q.command == CMD_RESERVE) ? mv_q - 1'b1 : mv_q + 1'b1;
    if (cmd_i.finish && res_status_i == ST_OK) begin
      if (req_q.command == CMD_RESERVE) cnt_d = cnt_q + 1'b1;
      else if (req_q.command == CMD_RELEASE) cnt_d = cnt_q - 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    mv_q  <= mv_d;
    pos_q <= pos_d;
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan && hit) begin
      hw_q <= wr_q[ix];
      hu_q <= us_q[ix];
    end
    // one entry moves per step; reserve writes slot 0 when mv reaches 0
    if (cmd_i.shift) begin
      if (req_q.command == CMD_RESERVE) begin
        if (mv_q == '0) begin
          start_q[0] <= req_q.address[31:PageShift];
          end_q[0]   <= r_end[32:PageShift];
          wr_q[0]    <= req_q.want_writable;
          us_q[0]    <= req_q.want_user;
        end else begin
          start_q[mx] <= start_q[mx-1'b1];
          end_q[mx]   <= end_q[mx-1'b1];
          wr_q[mx]    <= wr_q[mx-1'b1];
          us_q[mx]    <= us_q[mx-1'b1];
        end
      end else if (mv_q + 1'b1 < cnt_q) begin
        start_q[mx] <= start_q[mx+1'b1];
        end_q[mx]   <= end_q[mx+1'b1];
        wr_q[mx]    <= wr_q[mx+1'b1];
        us_q[mx]    <= us_q[mx+1'b1];
      end
    end
    if (cmd_i.finish) begin
      rsp_q.status         <= res_status_i;
      rsp_q.fault_action   <= ACT_NONE;
      rsp_q.map_writable   <= 1'b0;
      rsp_q.map_user       <= 1'b0;
      rsp_q.page_number    <= '0;
      rsp_q.regions_in_use <= 5'(cnt_d);
      if (req_q.command == CMD_FAULT) begin
        rsp_q.page_number <= 20'(req_q.address >> PageShift);
        if (res_status_i == ST_OK) begin
          rsp_q.fault_action <= req_q.fault_present ? ACT_COW : ACT_DEMAND;
          rsp_q.map_writable <= req_q.fault_present ? 1'b1 : hw_q;
          rsp_q.map_user     <= hu_q;
        end
      end
    end
  end

  assign rsp_o = rsp_q;
endmodule

@@ src/rtfc_ctrl.sv @@
// Sequencer for the region table: scan, move and response steps.
// Depends on rtfc_pkg.
module rtfc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rtfc_pkg::stat_t stat_i,
  output rtfc_pkg::cmd_t  cmd_o,
  output logic [2:0]      res_status_o
);
  import rtfc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      // prechecks before any scan
      S_CHECK: begin
        st_d = ST_OK;
        state_d = S_SCAN;
        priority case (cmd_e'(stat_i.command))
          CMD_RESERVE: if (stat_i.bad_align) begin
            st_d = ST_ALIGN; state_d = S_DONE;
          end
          CMD_RANGE: if (stat_i.range_zero) begin
            state_d = S_DONE;
          end else if (stat_i.bad_align) begin
            st_d = ST_DENY; state_d = S_DONE;
          end
          default: ;
        endcase
      end
      // one entry per cycle
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = S_DONE;
          unique case (cmd_e'(stat_i.command))
            CMD_RESERVE: if (stat_i.full) st_d = ST_FULL;
                         else state_d = S_MOVE;
            default: st_d = ST_DENY;
          endcase
        end else if (stat_i.hit) begin
          unique case (cmd_e'(stat_i.command))
            CMD_RESERVE: begin st_d = ST_OVERLAP; state_d = S_DONE; end
            CMD_RELEASE: begin cmd_o.scan = 1'b1; state_d = S_MOVE; end
            CMD_RANGE: begin
              if (stat_i.deny) begin
                st_d = ST_DENY; state_d = S_DONE;
              end else begin
                cmd_o.rescan = 1'b1; state_d = S_CHECK;
              end
            end
            default: begin
              // present page: only a write to a writable region is serviced
              cmd_o.scan = 1'b1;
              if (stat_i.no_service) st_d = ST_DENY;
              state_d = S_DONE;
            end
          endcase
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_MOVE: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // range check: after a rescan, stop once the end is covered
    if (state_q == S_CHECK && stat_i.command == CMD_RANGE && !stat_i.range_zero
        && !stat_i.bad_align && stat_i.range_done) begin
      state_d = S_DONE;
    end
  end

  // fault result: denied unless a hit allows service
  always_comb begin
    res_status_o = st_q;
  end
endmodule

@@ src/region_table_fault_classifier.sv @@
// Top level of the region table fault classifier.
// Depends on rtfc_pkg, rtfc_if, rtfc_ctrl, rtfc_datapath and the defines header.
//
//  channel  | dir | payload
//  req      | in  | command, address, length, want_*, fault_*
//  rsp      | out | status, fault_action, map_*, page_number, regions_in_use
//
// One command at a time: accept, check, a scan of one entry per step up to the
// end of the table, finish and result beat. Reserve also moves each entry in
// turn and then writes the new slot; release moves each entry after the hit.
// Range check returns to check after each region crossed and scans anew; all
// entries are examined through the single entry port.
// Reset clears the valid count and the sequencer; the result waits in a
// register until taken, and no new command is accepted meanwhile.
`include "region_table_fault_classifier_defines.svh"
module region_table_fault_classifier (
  input logic clk_i,
  input logic rst_ni,
  rtfc_if.sink   req,
  rtfc_if.source rsp
);
  import rtfc_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic [2:0] res_status;
  rsp_t rsp_data;

  rtfc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready),
    .out_valid_o (rsp.valid), .out_ready_i (rsp.ready),
    .stat_i (stat), .cmd_o (cmd), .res_status_o (res_status)
  );

  rtfc_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i (req.data), .cmd_i (cmd), .res_status_i (res_status),
    .stat_o (stat), .rsp_o (rsp_data)
  );

  assign rsp.data = rsp_data;

  `RTFC_ASSERT_IMP(a_no_in_when_busy, clk_i, rst_ni, rsp.valid, !req.ready)
  `RTFC_ASSERT_IMP(a_count_bound, clk_i, rst_ni, rsp.valid,
                   rsp.data.regions_in_use <= 5'(MaxRegions))
  `RTFC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, req.valid && req.ready, !req.ready)
endmodule
